>>> rtl/sorted_palette_nearest_color_unit_defines.svh
// Assertion macros for the sorted palette nearest color unit.
// Used by the top level only; no other dependencies.
`ifndef SORTED_PALETTE_NEAREST_COLOR_UNIT_DEFINES_SVH
`define SORTED_PALETTE_NEAREST_COLOR_UNIT_DEFINES_SVH
// Check that an antecedent implies a consequent in the next cycle.
`define SPNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Check that a condition holds in every cycle outside reset.
`define SPNC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
`endif

>>> rtl/spnc_pkg.sv
// Shared types and constants for the sorted palette nearest color unit.
// No dependencies.
`default_nettype none
package spnc_pkg;
  localparam int MAX_ENTRIES = 256;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [10:0] NO_MATCH_YET = 11'd1000;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SORT   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef logic [23:0] color_t;

  function automatic logic [7:0] grn(input color_t c);
    return c[15:8];
  endfunction

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction
endpackage
`default_nettype wire

>>> rtl/spnc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module spnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one address per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/sorted_palette_nearest_color_unit.sv
// Sorted palette nearest color unit: palette write, green sort, and lookup.
// Usage:
//   Requests enter on in_valid/in_ready with kind, entry_index and color.
//   Every request returns one result on out_valid/out_ready.
//   kind 0 writes a palette slot; the result is valid the cycle after the
//   accept, for a write and for an unused kind alike.
//   kind 1 selection-sorts the entries in use by green and builds the green
//   index.
//   kind 2 looks up a pixel and visits entries on both sides of the green
//   index, the entry that stops a side included; a lookup visits a few
//   entries up to all of them when many greens sit near the pixel.
//   One request is worked at a time; the palette RAM port sets the pace.
//   cfg_we writes entries_in_use from cfg_wdata; it is used clamped to
//   1..MAX_ENTRIES.
//   Reset makes the unit idle with entries_in_use = 256; the RAM contents
//   stay undefined until written.
//   The result is held in an output register while out_ready is low; the
//   next request is accepted only after the result leaves.
// Depends on spnc_pkg, spnc_ram and the defines header.
`default_nettype none
`include "sorted_palette_nearest_color_unit_defines.svh"
module sorted_palette_nearest_color_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [23:0] in_color,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_palette_position,
  output logic [23:0]      out_matched_color,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata
);
  import spnc_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_OUT    = 15'b000000000000010,
    S_SI_RD  = 15'b000000000000100,  // read a[i]
    S_SI_WT  = 15'b000000000001000,
    S_SJ_RD  = 15'b000000000010000,  // scan a[j]
    S_SJ_WT  = 15'b000000000100000,
    S_SW_A   = 15'b000000001000000,  // write a[i] = a[sp]
    S_SW_B   = 15'b000000010000000,  // write a[sp] = old a[i]
    S_IX     = 15'b000000100000000,  // index update for position i
    S_FILL   = 15'b000001000000000,  // fill index range
    S_L_IX   = 15'b000010000000000,  // read green index
    S_L_IXW  = 15'b000100000000000,
    S_L_RD   = 15'b001000000000000,  // read a candidate
    S_L_WT   = 15'b010000000000000,
    S_L_FIN  = 15'b100000000000000   // read best color
  } state_t;

  state_t state_r, state_nxt;
  logic [8:0] cnt_cfg_r;
  logic [CW-1:0] n_r;

  // RAM ports
  logic p_we, x_we;
  logic [AW-1:0] p_addr;
  logic [7:0] x_addr;
  color_t p_wdata, p_rdata;
  logic [7:0] x_wdata, x_rdata;

  spnc_ram #(.WIDTH(24), .DEPTH(MAX_ENTRIES)) u_pal (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
  spnc_ram #(.WIDTH(8), .DEPTH(256)) u_gix (
    .clk(clk), .we(x_we), .addr(x_addr), .wdata(x_wdata), .rdata(x_rdata));

  // Working registers
  logic [CW-1:0] i_r, j_r, sp_r, start_r;
  logic [8:0] prev_r, fj_r, fend_r;
  logic [7:0] fval_r;
  logic fix_r;               // index update still pending after fill
  color_t ci_r, csp_r, pix_r;
  logic [10:0] bestd_r;
  logic [CW-1:0] best_r;
  logic [CW:0] up_r, dn_r;   // dn signed in CW+1 bits
  logic side_r;              // 0 up, 1 down
  logic [7:0] pos_r;
  color_t col_r;

  logic [CW:0] n_ext;
  assign n_ext = {1'b0, n_r};
  logic up_ok, dn_ok;
  assign up_ok = up_r < n_ext;
  assign dn_ok = !dn_r[CW];

  // Distance of the candidate being read
  logic [8:0] gd;
  logic gneg;
  logic [10:0] dsum;
  always_comb begin
    if (!side_r) begin
      gneg = grn(p_rdata) < pix_r[15:8];
      gd = {1'b0, grn(p_rdata)} - {1'b0, pix_r[15:8]};
    end else begin
      gneg = pix_r[15:8] < grn(p_rdata);
      gd = {1'b0, pix_r[15:8]} - {1'b0, grn(p_rdata)};
    end
    dsum = {3'd0, absd(p_rdata[15:8], pix_r[15:8])}
         + {3'd0, absd(p_rdata[7:0], pix_r[7:0])}
         + {3'd0, absd(p_rdata[23:16], pix_r[23:16])};
  end
  logic stop_dir;
  assign stop_dir = !gneg && ({2'b0, gd} >= bestd_r);

  // Clamp the entry count at the start of a request
  logic [CW-1:0] n_clamp;
  always_comb begin
    if (cnt_cfg_r == 9'd0) n_clamp = CW'(1);
    else if ({1'b0, cnt_cfg_r} > 10'(MAX_ENTRIES)) n_clamp = CW'(MAX_ENTRIES);
    else n_clamp = CW'(cnt_cfg_r);
  end

  logic [CW-1:0] nm1;
  assign nm1 = n_r - CW'(1);
  logic accept;
  assign accept = in_valid && in_ready;
  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_palette_position = pos_r;
  assign out_matched_color = col_r;

  // Next lookup step: pick a live side, alternating up then down
  logic side_pick;
  always_comb begin
    side_pick = side_r;
    if (!side_r && !up_ok) side_pick = 1'b1;
    else if (side_r && !dn_ok) side_pick = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    p_we = 1'b0; p_addr = AW'(i_r); p_wdata = ci_r;
    x_we = 1'b0; x_addr = fj_r[7:0]; x_wdata = fval_r;
    case (state_r)
      S_IDLE:  if (accept && in_kind == KIND_WRITE) begin
        p_we = {1'b0, in_entry_index} < 9'(MAX_ENTRIES);
        p_addr = AW'(in_entry_index);
        p_wdata = in_color;
        state_nxt = S_OUT;
      end else if (accept && in_kind == KIND_SORT) begin
        state_nxt = S_SI_RD;
      end else if (accept && in_kind == KIND_LOOKUP) begin
        state_nxt = S_L_IX;
      end else if (accept) begin
        state_nxt = S_OUT;
      end
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      S_SI_RD: begin p_addr = AW'(i_r); state_nxt = S_SI_WT; end
      S_SI_WT: state_nxt = (j_r < n_r) ? S_SJ_RD : S_SW_A;
      S_SJ_RD: begin p_addr = AW'(j_r); state_nxt = S_SJ_WT; end
      S_SJ_WT: state_nxt = (j_r + CW'(1) < n_r) ? S_SJ_RD : S_SW_A;
      S_SW_A:  begin
        p_we = sp_r != i_r; p_addr = AW'(i_r); p_wdata = csp_r;
        state_nxt = S_SW_B;
      end
      S_SW_B:  begin
        p_we = sp_r != i_r; p_addr = AW'(sp_r); p_wdata = ci_r;
        state_nxt = S_IX;
      end
      S_IX, S_FILL: begin
        x_we = 1'b1; x_addr = fj_r[7:0]; x_wdata = fval_r;
        if (fj_r + 9'd1 < fend_r) state_nxt = S_FILL;
        else if (!fix_r) state_nxt = S_OUT;
        else if (i_r + CW'(1) < n_r) state_nxt = S_SI_RD;
        else state_nxt = S_IX;
      end
      S_L_IX:  begin x_addr = pix_r[15:8]; state_nxt = S_L_IXW; end
      S_L_IXW: state_nxt = S_L_RD;
      S_L_RD:  begin
        if (!up_ok && !dn_ok) begin
          p_addr = AW'(best_r); state_nxt = S_L_FIN;
        end else begin
          p_addr = AW'(side_pick ? dn_r : up_r); state_nxt = S_L_WT;
        end
      end
      S_L_WT:  state_nxt = S_L_RD;
      S_L_FIN: state_nxt = S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_cfg_r <= 9'd256;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cnt_cfg_r <= cfg_wdata;
    end
    case (state_r)
      S_IDLE: begin
        n_r <= n_clamp; pix_r <= in_color; pos_r <= '0; col_r <= '0;
        i_r <= '0; prev_r <= '0; start_r <= '0;
        bestd_r <= NO_MATCH_YET; best_r <= '0; side_r <= 1'b0;
      end
      S_SI_WT: begin ci_r <= p_rdata; csp_r <= p_rdata; sp_r <= i_r; end
      S_SJ_RD: ;
      S_SJ_WT: begin
        if (grn(p_rdata) < grn(csp_r)) begin csp_r <= p_rdata; sp_r <= j_r; end
        j_r <= j_r + CW'(1);
      end
      S_SW_B: begin
        // Plan the index update for the green now at position i
        fix_r <= 1'b1;
        if ({1'b0, grn(csp_r)} != prev_r) begin
          fj_r <= prev_r;
          fend_r <= {1'b0, grn(csp_r)};
          fval_r <= 8'((start_r + i_r) >> 1);
          prev_r <= {1'b0, grn(csp_r)};
          start_r <= i_r;
        end else begin
          // Same green as the run: rewrite its midpoint, settled when the run ends
          fj_r <= prev_r;
          fend_r <= prev_r;
          fval_r <= 8'((start_r + i_r) >> 1);
        end
      end
      S_IX, S_FILL: begin
        if (fj_r + 9'd1 < fend_r) begin
          fj_r <= fj_r + 9'd1;
          if (state_r == S_IX) fval_r <= 8'(i_r);
        end else if (fix_r && i_r + CW'(1) < n_r) begin
          i_r <= i_r + CW'(1); j_r <= i_r + CW'(2);
        end else if (fix_r) begin
          // Final run: midpoint then fill to 255
          fix_r <= 1'b0;
          fj_r <= prev_r;
          fend_r <= 9'd256;
          fval_r <= 8'((start_r + nm1) >> 1);
        end
      end
      S_L_IXW: begin up_r <= {1'b0, CW'(x_rdata)}; dn_r <= {1'b0, CW'(x_rdata)} - 1'b1;
        side_r <= 1'b0; end
      S_L_RD: side_r <= side_pick;
      S_L_WT: begin
        if (stop_dir) begin
          if (!side_r) up_r <= n_ext; else dn_r <= '1;
        end else begin
          if (dsum < bestd_r) begin
            bestd_r <= dsum; best_r <= side_r ? CW'(dn_r) : CW'(up_r);
          end
          if (!side_r) up_r <= up_r + 1'b1; else dn_r <= dn_r - 1'b1;
        end
        side_r <= !side_r;
      end
      S_L_FIN: begin pos_r <= 8'(best_r); col_r <= p_rdata; end
      default: ;
    endcase
    if (state_r == S_IDLE && accept && in_kind == KIND_SORT) j_r <= CW'(1);
  end

  `SPNC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `SPNC_ASSERT_ALWAYS(a_ready_excl, clk, rst_n, !(in_ready && out_valid), "ready while busy")
  `SPNC_ASSERT_NEXT(a_nonlookup, clk, rst_n, accept && in_kind != KIND_LOOKUP && in_kind != KIND_SORT, out_valid && out_palette_position == 8'd0, "nonzero position")
endmodule
`default_nettype wire
